[rtl/core/nllt_pkg.sv]
// Shared types and constants for the node lease liveness table.
`timescale 1ns / 1ps

package nllt_pkg;

    localparam int MAX_OUT   = 16;
    localparam int NOTICE_W  = $clog2(MAX_OUT + 1);
    localparam int CFG_IDX_W = 2;

    typedef enum logic [2:0] {
        OP_REGISTER    = 3'd0,
        OP_LOCAL_RENEW = 3'd1,
        OP_RENEW       = 3'd2,
        OP_SWEEP       = 3'd3,
        OP_QUERY       = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        ST_JOINING    = 3'd0,
        ST_ACTIVE     = 3'd1,
        ST_SUSPECT    = 3'd2,
        ST_DEAD       = 3'd3,
        ST_RECOVERING = 3'd4
    } t_node_state;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2
    } t_status;

    typedef enum logic {
        KIND_REPLY  = 1'b0,
        KIND_EXPIRY = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCAL_NODE = 2'd0,
        CFG_LEASE      = 2'd1,
        CFG_EXPIRY     = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [7:0]  node;
        t_node_state state;
        logic [31:0] renewed;
        logic [7:0]  missed;
        logic [31:0] epoch;
        logic [31:0] duration;
    } t_entry;

    typedef struct packed {
        logic start;
        logic rd;
        logic apply;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic is_find;
        logic is_sweep;
        logic count_zero;
        logic match;
        logic need_push;
        logic out_busy;
        logic walk_end;
    } t_dp_sts;

endpackage

[rtl/core/nllt_ctrl.sv]
// Sequencer for the table walk: start, entry read, entry check, final request.
`timescale 1ns / 1ps

module nllt_ctrl
    import nllt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_RD,
        S_CHK,
        S_FIN
    } t_state;

    t_state r_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd       = '0;
        o_cmd.start = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd    = (r_state == S_RD);
        o_cmd.apply = (r_state == S_CHK) && !(i_sts.need_push && i_sts.out_busy);
        o_cmd.fin   = (r_state == S_FIN) && !i_sts.out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_PREP;
                end
                S_PREP: begin
                    if ((i_sts.is_find || i_sts.is_sweep) && !i_sts.count_zero)
                        r_state <= S_RD;
                    else
                        r_state <= S_FIN;
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (o_cmd.apply) begin
                        if ((i_sts.is_find && i_sts.match) || i_sts.walk_end)
                            r_state <= S_FIN;
                        else
                            r_state <= S_RD;
                    end
                end
                S_FIN: begin
                    if (!i_sts.out_busy) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted but controller stayed idle");

endmodule

[rtl/core/nllt_dp.sv]
// Datapath: configuration, entry memory, lease arithmetic and output register.
`timescale 1ns / 1ps

module nllt_dp
    import nllt_pkg::*;
#(
    parameter int MAX_NODES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic [2:0]           i_opcode,
    input  logic [7:0]           i_node_id,
    input  logic [31:0]          i_epoch,
    input  logic [31:0]          i_time_now,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_kind,
    output logic [1:0]           o_status,
    output logic [7:0]           o_target_node,
    output logic                 o_lease_valid,
    output logic [2:0]           o_node_state,
    output logic [7:0]           o_missed_count,
    output logic                 o_last
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    logic [7:0]  r_cfg_local;
    logic [31:0] r_cfg_lease;
    logic [31:0] r_cfg_expiry;

    logic [CW-1:0] r_count;
    logic [2:0]    r_op;
    logic [7:0]    r_node;
    logic [7:0]    r_key;
    logic [31:0]   r_epoch;
    logic [31:0]   r_now;

    logic [IW-1:0]       r_idx;
    logic [NOTICE_W-1:0] r_notices;
    logic                r_pend_valid;
    logic [7:0]          r_pend_node;

    logic        r_hit;
    logic [2:0]  r_hit_state;
    logic [7:0]  r_hit_missed;
    logic        r_hit_valid;

    t_entry r_mem [MAX_NODES];
    t_entry r_rd;

    logic        r_out_valid;
    logic        r_out_kind;
    logic [1:0]  r_out_status;
    logic [7:0]  r_out_target;
    logic        r_out_lease;
    logic [2:0]  r_out_state;
    logic [7:0]  r_out_missed;
    logic        r_out_last;

    logic [31:0]         elapsed;
    logic                live, skip, expire, lapse, qvalid, notice, match;
    logic                is_find, is_sweep, is_renew, full, push, out_busy;
    logic [NOTICE_W-1:0] notices_next;
    logic [IW:0]         idx_inc;
    t_entry              upd, new_entry, w_data;
    logic                w_en;
    logic [IW-1:0]       w_addr;

    logic        f_kind;
    logic [1:0]  f_status;
    logic [7:0]  f_target;
    logic        f_lease;
    logic [2:0]  f_state;
    logic [7:0]  f_missed;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_local  <= '0;
            r_cfg_lease  <= '0;
            r_cfg_expiry <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOCAL_NODE: r_cfg_local  <= i_cfg_data[7:0];
                CFG_LEASE:      r_cfg_lease  <= i_cfg_data;
                CFG_EXPIRY:     r_cfg_expiry <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // entry checks on the registered read
    assign elapsed  = r_now - r_rd.renewed;
    assign match    = (r_rd.node == r_key);
    assign live     = (r_rd.state != ST_DEAD) && (r_rd.state != ST_RECOVERING);
    assign skip     = (r_rd.node == r_cfg_local) || !live || (r_rd.renewed == 32'd0);
    assign expire   = (elapsed >= r_cfg_expiry);
    assign lapse    = (elapsed >= r_cfg_lease);
    assign qvalid   = live && (r_rd.renewed != 32'd0) && (elapsed < r_rd.duration);

    assign is_sweep = (r_op == OP_SWEEP);
    assign is_renew = (r_op == OP_LOCAL_RENEW) || (r_op == OP_RENEW);
    assign is_find  = (r_op == OP_REGISTER) || is_renew || (r_op == OP_QUERY);
    assign full     = (r_count == CW'(MAX_NODES));
    assign notice   = is_sweep && !skip && expire;

    assign notices_next = r_notices + {{(NOTICE_W-1){1'b0}}, notice};
    assign idx_inc      = {1'b0, r_idx} + (IW+1)'(1);
    assign out_busy     = r_out_valid && !i_out_ready;
    assign push         = i_cmd.apply && is_sweep && notice && r_pend_valid;

    always_comb begin
        o_sts            = '0;
        o_sts.is_find    = is_find;
        o_sts.is_sweep   = is_sweep;
        o_sts.count_zero = (r_count == '0);
        o_sts.match      = match;
        o_sts.need_push  = is_sweep && notice && r_pend_valid;
        o_sts.out_busy   = out_busy;
        o_sts.walk_end   = (idx_inc >= (IW+1)'(r_count)) ||
                           (is_sweep && (notices_next == NOTICE_W'(MAX_OUT)));
    end

    always_comb begin
        upd = r_rd;
        unique case (r_op)
            OP_LOCAL_RENEW: begin
                upd.renewed = r_now;
                upd.state   = ST_ACTIVE;
                upd.missed  = '0;
            end
            OP_RENEW: begin
                upd.renewed = r_now;
                upd.epoch   = r_epoch;
                upd.missed  = '0;
                if (r_rd.state == ST_JOINING || r_rd.state == ST_SUSPECT)
                    upd.state = ST_ACTIVE;
            end
            OP_SWEEP: begin
                if (expire) begin
                    upd.state  = ST_DEAD;
                    upd.missed = '0;
                end else if (lapse &&
                             (r_rd.state == ST_ACTIVE || r_rd.state == ST_SUSPECT)) begin
                    upd.state = ST_SUSPECT;
                    if (r_rd.missed != 8'hFF) upd.missed = r_rd.missed + 8'd1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        new_entry          = '0;
        new_entry.node     = r_node;
        new_entry.state    = (r_node == r_cfg_local) ? ST_ACTIVE : ST_JOINING;
        new_entry.renewed  = r_now;
        new_entry.duration = r_cfg_lease;
    end

    always_comb begin
        w_en   = 1'b0;
        w_addr = r_idx;
        w_data = upd;
        if (i_cmd.apply) begin
            w_en = (is_sweep && !skip) || (is_renew && match);
        end else if (i_cmd.fin && (r_op == OP_REGISTER) && !r_hit && !full) begin
            w_en   = 1'b1;
            w_addr = r_count[IW-1:0];
            w_data = new_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_mem[w_addr] <= w_data;
        if (i_cmd.rd) r_rd <= r_mem[r_idx];
    end

    // final request of the operation
    always_comb begin
        f_kind   = KIND_REPLY;
        f_status = STS_OK;
        f_target = r_key;
        f_lease  = 1'b0;
        f_state  = ST_JOINING;
        f_missed = '0;
        if (is_sweep) begin
            if (r_pend_valid) begin
                f_kind   = KIND_EXPIRY;
                f_target = r_pend_node;
                f_state  = ST_DEAD;
            end else begin
                f_target = r_node;
            end
        end else if (is_find) begin
            if (r_hit) begin
                f_lease  = r_hit_valid;
                f_state  = r_hit_state;
                f_missed = r_hit_missed;
            end else if (r_op == OP_REGISTER) begin
                if (full) begin
                    f_status = STS_FULL;
                end else begin
                    f_state = new_entry.state;
                end
            end else begin
                f_status = STS_NOT_FOUND;
            end
        end else begin
            f_target = r_node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_hit        <= 1'b0;
            r_notices    <= '0;
            r_idx        <= '0;
            r_op         <= OP_REGISTER;
        end else begin
            if (i_cmd.start) begin
                r_op         <= i_opcode;
                r_node       <= i_node_id;
                r_key        <= (i_opcode == OP_LOCAL_RENEW) ? r_cfg_local : i_node_id;
                r_epoch      <= i_epoch;
                r_now        <= i_time_now;
                r_idx        <= '0;
                r_notices    <= '0;
                r_pend_valid <= 1'b0;
                r_hit        <= 1'b0;
            end
            if (i_cmd.apply) begin
                r_idx     <= r_idx + IW'(1);
                r_notices <= notices_next;
                if (is_find && match) begin
                    r_hit        <= 1'b1;
                    r_hit_state  <= upd.state;
                    r_hit_missed <= upd.missed;
                    r_hit_valid  <= (r_op == OP_QUERY) && qvalid;
                end
                if (notice) begin
                    r_pend_valid <= 1'b1;
                    r_pend_node  <= r_rd.node;
                end
            end
            if (i_cmd.fin && (r_op == OP_REGISTER) && !r_hit && !full)
                r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid  <= 1'b1;
            r_out_kind   <= f_kind;
            r_out_status <= f_status;
            r_out_target <= f_target;
            r_out_lease  <= f_lease;
            r_out_state  <= f_state;
            r_out_missed <= f_missed;
            r_out_last   <= 1'b1;
        end else if (push) begin
            r_out_valid  <= 1'b1;
            r_out_kind   <= KIND_EXPIRY;
            r_out_status <= STS_OK;
            r_out_target <= r_pend_node;
            r_out_lease  <= 1'b0;
            r_out_state  <= ST_DEAD;
            r_out_missed <= '0;
            r_out_last   <= 1'b0;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_status       = r_out_status;
    assign o_target_node  = r_out_target;
    assign o_lease_valid  = r_out_lease;
    assign o_node_state   = r_out_state;
    assign o_missed_count = r_out_missed;
    assign o_last         = r_out_last;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_NODES))
        else $error("entry count beyond table depth");

    a_notice_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_notices <= NOTICE_W'(MAX_OUT))
        else $error("too many expiry notices in one sweep");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fin || push) |-> !out_busy)
        else $error("output register loaded while still held");

    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> (o_out_valid && o_last))
        else $error("final request not marked last");

endmodule

[rtl/core/node_lease_liveness_table.sv]
// Top level of the node lease liveness table.
`timescale 1ns / 1ps

// Lease table of up to MAX_NODES cluster nodes, one request at a time. A request
// is taken when the block is idle; the entry memory has one registered read port,
// so the walk reads each entry and then checks it. Register, renew and query walk
// up to the match (or over all entries on a miss); a sweep walks all entries but
// stops after MAX_OUT expiry notices, and waits while the result side stalls
// on expiry notices. Any request also holds in its final state while the previous
// result still waits unaccepted. Results sit in an output register, so the next
// request is taken while the last result still waits. The entry memory is not
// cleared after reset; only entries below the fill count are read.

module node_lease_liveness_table
    import nllt_pkg::*;
#(
    parameter int MAX_NODES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [2:0]           i_opcode,
    input  logic [7:0]           i_node_id,
    input  logic [31:0]          i_epoch,
    input  logic [31:0]          i_time_now,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_kind,
    output logic [1:0]           o_status,
    output logic [7:0]           o_target_node,
    output logic                 o_lease_valid,
    output logic [2:0]           o_node_state,
    output logic [7:0]           o_missed_count,
    output logic                 o_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    nllt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    nllt_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_node_id      (i_node_id),
        .i_epoch        (i_epoch),
        .i_time_now     (i_time_now),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_status       (o_status),
        .o_target_node  (o_target_node),
        .o_lease_valid  (o_lease_valid),
        .o_node_state   (o_node_state),
        .o_missed_count (o_missed_count),
        .o_last         (o_last)
    );

endmodule

[tb/tb_node_lease_liveness_table.sv]
// Testbench for the node lease liveness table: scripted requests, then random lease traffic.
`timescale 1ns / 1ps

module tb_node_lease_liveness_table;
    import nllt_pkg::*;

    localparam int          TABLE_DEPTH    = 16;
    localparam int          POOL_N         = 20;
    localparam int          SETTLE_CYCLES  = 60;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam logic [2:0]  OP_BAD_FIRST   = 3'd5;
    localparam logic [2:0]  OP_BAD_LAST    = 3'd7;
    localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
    localparam logic [7:0]  MISSED_MAX     = 8'hFF;

    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [7:0]  target;
        logic        valid;
        t_node_state state;
        logic [7:0]  missed;
        logic        last;
    } t_lease_item;

    typedef struct {
        bit          is_cfg;
        t_cfg_index  cfg_idx;
        logic [31:0] cfg_val;
        logic [2:0]  op;
        logic [7:0]  node;
        logic [31:0] epoch;
        logic [31:0] now;
        bit          typed;
        t_lease_item want;
    } t_script_row;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic [1:0]  cfg_index  = '0;
    logic [31:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic [2:0]  opcode     = '0;
    logic [7:0]  node_id    = '0;
    logic [31:0] epoch      = '0;
    logic [31:0] time_now   = '0;
    logic        out_ready  = 1'b0;

    logic        o_cfg_ready;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_kind;
    logic [1:0]  o_status;
    logic [7:0]  o_target_node;
    logic        o_lease_valid;
    logic [2:0]  o_node_state;
    logic [7:0]  o_missed_count;
    logic        o_last;

    // lease table mirror
    int          tbl_count = 0;
    logic [7:0]  tbl_node     [TABLE_DEPTH];
    t_node_state tbl_state    [TABLE_DEPTH];
    logic [31:0] tbl_renewed  [TABLE_DEPTH];
    logic [7:0]  tbl_missed   [TABLE_DEPTH];
    logic [31:0] tbl_epoch    [TABLE_DEPTH];
    logic [31:0] tbl_duration [TABLE_DEPTH];
    logic [7:0]  cur_local  = '0;
    logic [31:0] cur_lease  = '0;
    logic [31:0] cur_expiry = '0;

    t_lease_item step_items[$];
    t_lease_item lease_results_due[$];
    t_script_row script[$];
    logic [7:0]  pool[POOL_N];
    logic [31:0] clock_ms = '0;
    bit          quiet = 1'b0;
    int          errors = 0;

    node_lease_liveness_table #(
        .MAX_NODES(TABLE_DEPTH)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (opcode),
        .i_node_id      (node_id),
        .i_epoch        (epoch),
        .i_time_now     (time_now),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_kind         (o_kind),
        .o_status       (o_status),
        .o_target_node  (o_target_node),
        .o_lease_valid  (o_lease_valid),
        .o_node_state   (o_node_state),
        .o_missed_count (o_missed_count),
        .o_last         (o_last)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int find_slot(logic [7:0] id);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_node[i] == id) return i;
        end
        return -1;
    endfunction

    function automatic void apply_lease_op(logic [2:0] op, logic [7:0] node,
                                           logic [31:0] ep, logic [31:0] now);
        int          slot;
        logic [31:0] elapsed;
        t_lease_item reply;
        step_items.delete();
        reply = '0;
        reply.target = node;
        slot = -1;
        case (op)
            OP_REGISTER: begin
                slot = find_slot(node);
                if (slot < 0 && tbl_count < TABLE_DEPTH) begin
                    slot = tbl_count;
                    tbl_node[slot]     = node;
                    tbl_state[slot]    = (node == cur_local) ? ST_ACTIVE : ST_JOINING;
                    tbl_renewed[slot]  = now;
                    tbl_missed[slot]   = '0;
                    tbl_epoch[slot]    = '0;
                    tbl_duration[slot] = cur_lease;
                    tbl_count++;
                end
                if (slot < 0) reply.status = STS_FULL;
            end
            OP_LOCAL_RENEW: begin
                reply.target = cur_local;
                slot = find_slot(cur_local);
                if (slot >= 0) begin
                    tbl_renewed[slot] = now;
                    tbl_state[slot]   = ST_ACTIVE;
                    tbl_missed[slot]  = '0;
                end else begin
                    reply.status = STS_NOT_FOUND;
                end
            end
            OP_RENEW: begin
                slot = find_slot(node);
                if (slot >= 0) begin
                    tbl_renewed[slot] = now;
                    tbl_epoch[slot]   = ep;
                    tbl_missed[slot]  = '0;
                    if (tbl_state[slot] == ST_JOINING || tbl_state[slot] == ST_SUSPECT)
                        tbl_state[slot] = ST_ACTIVE;
                end else begin
                    reply.status = STS_NOT_FOUND;
                end
            end
            OP_QUERY: begin
                slot = find_slot(node);
                if (slot >= 0) begin
                    elapsed = now - tbl_renewed[slot];
                    reply.valid = tbl_state[slot] != ST_DEAD &&
                                  tbl_state[slot] != ST_RECOVERING &&
                                  tbl_renewed[slot] != 0 && elapsed < tbl_duration[slot];
                end else begin
                    reply.status = STS_NOT_FOUND;
                end
            end
            OP_SWEEP: begin
                for (int i = 0; i < tbl_count && step_items.size() < MAX_OUT; i++) begin
                    if (tbl_node[i] == cur_local || tbl_state[i] == ST_DEAD ||
                        tbl_state[i] == ST_RECOVERING || tbl_renewed[i] == 0)
                        continue;
                    elapsed = now - tbl_renewed[i];
                    if (elapsed >= cur_expiry) begin
                        t_lease_item notice;
                        notice = '0;
                        notice.kind   = KIND_EXPIRY;
                        notice.target = tbl_node[i];
                        notice.state  = ST_DEAD;
                        tbl_state[i]  = ST_DEAD;
                        tbl_missed[i] = '0;
                        step_items.push_back(notice);
                    end else if (elapsed >= cur_lease &&
                                 (tbl_state[i] == ST_ACTIVE || tbl_state[i] == ST_SUSPECT)) begin
                        tbl_state[i] = ST_SUSPECT;
                        if (tbl_missed[i] != MISSED_MAX) tbl_missed[i] = tbl_missed[i] + 8'd1;
                    end
                end
            end
            default: ;
        endcase
        if (slot >= 0) begin
            reply.state  = tbl_state[slot];
            reply.missed = tbl_missed[slot];
        end
        if (step_items.size() == 0) step_items.push_back(reply);
        step_items[step_items.size() - 1].last = 1'b1;
    endfunction

    function automatic t_lease_item mk_item(t_kind k, t_status s, logic [7:0] tgt, logic v,
                                            t_node_state st, logic [7:0] m);
        t_lease_item it;
        it.kind   = k;
        it.status = s;
        it.target = tgt;
        it.valid  = v;
        it.state  = st;
        it.missed = m;
        it.last   = 1'b1;
        return it;
    endfunction

    function automatic void add_req(logic [2:0] op, logic [7:0] node, logic [31:0] ep,
                                    logic [31:0] now, bit typed, t_lease_item want);
        t_script_row row;
        row.is_cfg  = 1'b0;
        row.cfg_idx = CFG_LOCAL_NODE;
        row.cfg_val = '0;
        row.op      = op;
        row.node    = node;
        row.epoch   = ep;
        row.now     = now;
        row.typed   = typed;
        row.want    = want;
        script.push_back(row);
    endfunction

    function automatic void add_cfg(t_cfg_index idx, logic [31:0] val);
        t_script_row row;
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        row.op      = '0;
        row.node    = '0;
        row.epoch   = '0;
        row.now     = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        script.push_back(row);
    endfunction

    task automatic send_request(logic [2:0] op, logic [7:0] node, logic [31:0] ep,
                                logic [31:0] now, bit typed, t_lease_item want);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        node_id  <= node;
        epoch    <= ep;
        time_now <= now;
        do @(posedge clk); while (!o_in_ready);
        apply_lease_op(op, node, ep, now);
        if (typed) begin
            lease_results_due.push_back(want);
        end else begin
            foreach (step_items[k]) lease_results_due.push_back(step_items[k]);
        end
    endtask

    // registers change only with the table idle
    task automatic write_cfg(t_cfg_index idx, logic [31:0] val);
        in_valid <= 1'b0;
        while (lease_results_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LOCAL_NODE: cur_local  = val[7:0];
            CFG_LEASE:      cur_lease  = val;
            CFG_EXPIRY:     cur_expiry = val;
            default: ;
        endcase
    endtask

    function automatic logic [7:0] pick_node(int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return pool[$urandom_range(0, span - 1)];
        if (r < 95) return cur_local;
        return 8'($urandom);
    endfunction

    task automatic run_phase(int n_items, int w_reg, int w_loc, int w_renew, int w_sweep,
                             int w_query, int w_bad, int renew_span, int step_max);
        int          r;
        logic [2:0]  op;
        logic [7:0]  node;
        logic [31:0] now;
        t_lease_item none;
        none = '0;
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(0, w_reg + w_loc + w_renew + w_sweep + w_query + w_bad - 1);
            if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
            else clock_ms = clock_ms + $urandom_range(0, step_max);
            now  = clock_ms;
            node = 8'($urandom);
            if (r < w_reg) begin
                op = OP_REGISTER;
                node = pick_node(POOL_N);
            end else if (r < w_reg + w_loc) begin
                op = OP_LOCAL_RENEW;
            end else if (r < w_reg + w_loc + w_renew) begin
                op = OP_RENEW;
                node = pick_node(renew_span);
            end else if (r < w_reg + w_loc + w_renew + w_sweep) begin
                op = OP_SWEEP;
            end else if (r < w_reg + w_loc + w_renew + w_sweep + w_query) begin
                op = OP_QUERY;
                node = pick_node(POOL_N);
            end else begin
                op  = 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
                now = $urandom;
            end
            send_request(op, node, $urandom, now, 1'b0, none);
        end
    endtask

    initial begin : result_side
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    always @(posedge clk) begin : result_check
        t_lease_item got;
        t_lease_item want;
        if (rst_n && o_out_valid && out_ready) begin
            got.kind   = t_kind'(o_kind);
            got.status = t_status'(o_status);
            got.target = o_target_node;
            got.valid  = o_lease_valid;
            got.state  = t_node_state'(o_node_state);
            got.missed = o_missed_count;
            got.last   = o_last;
            if (lease_results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result kind=%0d status=%0d node=%02h valid=%0d",
                         $time, got.kind, got.status, got.target, got.valid,
                         " state=%0d missed=%0d last=%0d", got.state, got.missed, got.last);
            end else begin
                want = lease_results_due.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch expected kind=%0d status=%0d node=%02h valid=%0d",
                             $time, want.kind, want.status, want.target, want.valid,
                             " state=%0d missed=%0d last=%0d", want.state, want.missed,
                             want.last,
                             " actual kind=%0d status=%0d node=%02h valid=%0d", got.kind,
                             got.status, got.target, got.valid,
                             " state=%0d missed=%0d last=%0d", got.state, got.missed,
                             got.last);
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_node_lease_liveness_table failed");
        $finish;
    end

    initial begin : stimulus
        t_lease_item none;
        logic [7:0]  seed;
        none = '0;
        seed = 8'($urandom);
        for (int i = 0; i < POOL_N; i++) pool[i] = seed + 8'(i * 37);

        // reset config: local 0, lease 0, expiry 0
        add_req(OP_QUERY, 8'h00, 0, 1, 1'b1,
                mk_item(KIND_REPLY, STS_NOT_FOUND, 8'h00, 1'b0, ST_JOINING, 8'd0));
        add_req(OP_LOCAL_RENEW, 8'hFF, 0, 1, 1'b1,
                mk_item(KIND_REPLY, STS_NOT_FOUND, 8'h00, 1'b0, ST_JOINING, 8'd0));
        add_req(OP_RENEW, 8'hFF, ALL_ONES, 2, 1'b1,
                mk_item(KIND_REPLY, STS_NOT_FOUND, 8'hFF, 1'b0, ST_JOINING, 8'd0));
        add_req(OP_SWEEP, 8'h5A, 0, 100, 1'b1,
                mk_item(KIND_REPLY, STS_OK, 8'h5A, 1'b0, ST_JOINING, 8'd0));
        add_req(OP_REGISTER, 8'h00, 0, 0, 1'b1,
                mk_item(KIND_REPLY, STS_OK, 8'h00, 1'b0, ST_ACTIVE, 8'd0));
        add_req(OP_REGISTER, 8'hFF, 0, ALL_ONES, 1'b1,
                mk_item(KIND_REPLY, STS_OK, 8'hFF, 1'b0, ST_JOINING, 8'd0));
        add_req(OP_REGISTER, 8'hFF, 0, 5, 1'b1,
                mk_item(KIND_REPLY, STS_OK, 8'hFF, 1'b0, ST_JOINING, 8'd0));
        add_req(OP_QUERY, 8'hFF, 0, 3, 1'b0, none);
        add_req(OP_RENEW, 8'hFF, ALL_ONES, 32'hFFFF_FFF0, 1'b0, none);
        add_req(OP_LOCAL_RENEW, 8'h00, 0, 0, 1'b0, none);
        add_req(OP_REGISTER, 8'hA5, 0, 0, 1'b0, none);
        add_req(OP_SWEEP, 8'h00, 0, 32'h8000_0000, 1'b0, none);
        add_req(OP_RENEW, 8'hFF, 1, 32'h8000_0001, 1'b0, none);
        add_req(OP_BAD_FIRST, 8'h3C, 0, 0, 1'b1,
                mk_item(KIND_REPLY, STS_OK, 8'h3C, 1'b0, ST_JOINING, 8'd0));
        add_req(OP_BAD_LAST, 8'hFF, ALL_ONES, ALL_ONES, 1'b1,
                mk_item(KIND_REPLY, STS_OK, 8'hFF, 1'b0, ST_JOINING, 8'd0));
        add_req(OP_QUERY, 8'hA5, 0, 10, 1'b0, none);
        add_req(OP_RENEW, 8'hA5, 32'h1234_5678, 1000, 1'b0, none);
        add_req(OP_SWEEP, 8'h00, 0, 1000, 1'b0, none);
        // suspect path
        add_cfg(CFG_LEASE, 10);
        add_cfg(CFG_EXPIRY, ALL_ONES);
        add_req(OP_REGISTER, 8'h11, 0, 100, 1'b0, none);
        add_req(OP_RENEW, 8'h11, 32'hA5A5_5A5A, 100, 1'b0, none);
        add_req(OP_SWEEP, 8'h11, 0, 200, 1'b0, none);
        add_req(OP_QUERY, 8'h11, 0, 105, 1'b0, none);
        add_req(OP_REGISTER, 8'h11, 0, 300, 1'b0, none);
        add_req(OP_QUERY, 8'h11, 0, 200, 1'b0, none);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[r]) begin
            if (script[r].is_cfg)
                write_cfg(script[r].cfg_idx, script[r].cfg_val);
            else
                send_request(script[r].op, script[r].node, script[r].epoch, script[r].now,
                             script[r].typed, script[r].want);
        end

        // sweep-heavy, most nodes never renewed: missed count runs into saturation
        write_cfg(CFG_LOCAL_NODE, {24'd0, pool[0]});
        write_cfg(CFG_LEASE, 150);
        write_cfg(CFG_EXPIRY, ALL_ONES);
        clock_ms = $urandom;
        for (int i = 0; i < POOL_N; i++)
            send_request(OP_REGISTER, pool[i], $urandom, clock_ms, 1'b0, none);
        run_phase(300, 3, 2, 3, 88, 3, 1, 4, 100);

        write_cfg(CFG_LOCAL_NODE, 32'd255);
        write_cfg(CFG_LEASE, ALL_ONES);
        write_cfg(CFG_EXPIRY, 400);
        run_phase(60, 10, 10, 30, 25, 20, 5, POOL_N, 150);

        write_cfg(CFG_LOCAL_NODE, {24'd0, pool[3]});
        write_cfg(CFG_LEASE, 200);
        write_cfg(CFG_EXPIRY, 1000);
        run_phase(50, 8, 8, 30, 30, 20, 4, POOL_N, 120);

        quiet = 1'b1;
        write_cfg(CFG_LOCAL_NODE, 32'd0);
        write_cfg(CFG_LEASE, 32'd0);
        write_cfg(CFG_EXPIRY, 32'd0);
        run_phase(40, 8, 10, 25, 30, 22, 5, POOL_N, 50);

        in_valid <= 1'b0;
        while (lease_results_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("tb_node_lease_liveness_table passed");
        end else begin
            $display("tb_node_lease_liveness_table failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/nllt_pkg.sv
rtl/core/nllt_ctrl.sv
rtl/core/nllt_dp.sv
rtl/core/node_lease_liveness_table.sv
tb/tb_node_lease_liveness_table.sv
